/* rtl/pdw_pkg.sv */
`timescale 1ns / 1ps

package pdw_pkg;

	// Store geometry.
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(STORE_SIZE);

	// Field widths.
	localparam int DIM_W    = 9;
	localparam int COORD_W  = 12;
	localparam int DEPTH_W  = 24;
	localparam int NORMAL_W = 16;
	localparam int COLOR_W  = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;

	// Wide enough for the largest frame dimension and for a coordinate.
	localparam int EXT_W = 13;

	// Shading arithmetic: d fits 18 bits signed, its positive part 17 bits.
	localparam int DOT_W    = NORMAL_W + 2;
	localparam int PROD_W   = 31;
	localparam int FACTOR_W = 16;
	localparam logic [PROD_W-1:0] INV_SQRT3_Q14 = PROD_W'(9459);
	localparam logic [PROD_W:0]   Q14_HALF      = (PROD_W + 1)'(8192);

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PLOT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OOB    = 2'd2;

	// Configuration register indexes.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_CLEAR,
		ST_READ,
		ST_CHECK,
		ST_FINISH
	} state_t;

endpackage

/* rtl/pdw_ram.sv */
`timescale 1ns / 1ps

// Single-port synchronous RAM, read-first, with a registered read.
module pdw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* rtl/shaded_depth_tested_pixel_writer_unit.sv */
`timescale 1ns / 1ps

// Depth-tested, Lambert-shaded pixel writer. Colour and depth live in two
// single-port RAMs of MAX_WIDTH*MAX_HEIGHT entries, addressed as y*width+x, and
// every command goes through one read-modify-write sequence on them, one item
// at a time. A plot or a read passes through accept, address and shading
// product, RAM read, depth compare and write-back, and result hand-over; an
// out-of-bounds item or an unknown command goes from the address step straight
// to the hand-over. A clear writes one entry per cycle through the whole store.
// The stores hold nothing meaningful after reset: a clear must come
// before any plot or read. A finished result sits in an output register, so
// the next item is taken while the previous result still waits for its
// transfer; the frame registers may only be written while the block is idle.
module shaded_depth_tested_pixel_writer_unit (
	input  logic         clk,
	input  logic         arst_n,

	// Configuration writes: index 0 frame_width, index 1 frame_height.
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [8:0]   cfg_data,

	// Input items.
	input  logic         s_tvalid,
	output logic         s_tready,
	// x_coord[11:0], y_coord[23:12], depth_in[47:24], normal_x[63:48],
	// normal_y[79:64], normal_z[95:80], color_in[127:96]
	input  logic [127:0] s_tdata,
	// command[1:0]
	input  logic [1:0]   s_tuser,

	// Result items.
	output logic         m_tvalid,
	input  logic         m_tready,
	// color_out[31:0], depth_out[55:32]
	output logic [55:0]  m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser
);

	localparam int AW = pdw_pkg::ADDR_W;

	pdw_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [pdw_pkg::DIM_W-1:0] frame_width_q, frame_height_q;

	// Latched input item.
	logic [pdw_pkg::CMD_W-1:0]    cmd_q;
	logic [pdw_pkg::COORD_W-1:0]  x_q, y_q;
	logic [pdw_pkg::DEPTH_W-1:0]  depth_q;
	logic [pdw_pkg::NORMAL_W-1:0] nx_q, ny_q, nz_q;
	logic [pdw_pkg::COLOR_W-1:0]  color_q;

	// Working registers.
	logic [AW-1:0]                  addr_q;
	logic [AW-1:0]                  sweep_q;
	logic [pdw_pkg::PROD_W-1:0]     prod_q;
	logic [pdw_pkg::FACTOR_W-1:0]   factor_q;
	logic [pdw_pkg::STATUS_W-1:0]   status_q;
	logic [pdw_pkg::COLOR_W-1:0]    res_color_q;
	logic [pdw_pkg::DEPTH_W-1:0]    res_depth_q;

	// Output register.
	logic                           m_valid_q;
	logic [55:0]                    m_data_q;
	logic [1:0]                     m_user_q;

	// RAM ports.
	logic                           mem_we;
	logic [AW-1:0]                  mem_addr;
	logic [pdw_pkg::COLOR_W-1:0]    mem_color_wr, mem_color_rd;
	logic [pdw_pkg::DEPTH_W-1:0]    mem_depth_wr, mem_depth_rd;

	logic in_xfer, out_load, sweep_last, oob, reject;
	logic [pdw_pkg::EXT_W-1:0]     w_eff, h_eff, x_ext, y_ext;
	logic [2*pdw_pkg::EXT_W:0]     idx_full;
	logic [pdw_pkg::DOT_W-1:0]     dot;
	logic [pdw_pkg::COLOR_W-1:0]   shaded;

	assign in_xfer    = s_tvalid && s_tready;
	assign sweep_last = (sweep_q == AW'(pdw_pkg::STORE_SIZE - 1));

	// The active frame is the register value clipped to the store size.
	always_comb begin
		w_eff = pdw_pkg::EXT_W'(frame_width_q);
		if (w_eff > pdw_pkg::EXT_W'(pdw_pkg::MAX_WIDTH)) begin
			w_eff = pdw_pkg::EXT_W'(pdw_pkg::MAX_WIDTH);
		end
		h_eff = pdw_pkg::EXT_W'(frame_height_q);
		if (h_eff > pdw_pkg::EXT_W'(pdw_pkg::MAX_HEIGHT)) begin
			h_eff = pdw_pkg::EXT_W'(pdw_pkg::MAX_HEIGHT);
		end
	end

	// Bounds and row-major address, from the latched coordinates.
	assign x_ext    = {1'b0, x_q};
	assign y_ext    = {1'b0, y_q};
	assign idx_full = (2*pdw_pkg::EXT_W+1)'(y_ext * w_eff)
		+ (2*pdw_pkg::EXT_W+1)'(x_ext);
	assign oob = x_q[pdw_pkg::COORD_W-1] || y_q[pdw_pkg::COORD_W-1]
		|| (x_ext >= w_eff) || (y_ext >= h_eff)
		|| (idx_full >= (2*pdw_pkg::EXT_W+1)'(pdw_pkg::STORE_SIZE));

	// Light direction (1,1,-1): only the positive part of the dot product counts.
	assign dot = pdw_pkg::DOT_W'($signed(nx_q)) + pdw_pkg::DOT_W'($signed(ny_q))
		- pdw_pkg::DOT_W'($signed(nz_q));

	// Per-channel scaling by the registered factor, saturated to a byte.
	always_comb begin
		logic [23:0] ch_prod;
		shaded = '0;
		for (int k = 0; k < 4; k++) begin
			ch_prod = 24'(color_q[8*k +: 8]) * 24'(factor_q);
			shaded[8*k +: 8] = (|ch_prod[23:22]) ? 8'hFF : ch_prod[21:14];
		end
	end

	// Farther than what is stored: equal depth still passes.
	assign reject = (depth_q > mem_depth_rd);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		mem_we   = 1'b0;
		mem_addr = addr_q;
		out_load = 1'b0;
		case (state_q)
			pdw_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = pdw_pkg::ST_CALC;
				end
			end
			pdw_pkg::ST_CALC: begin
				if (cmd_q == pdw_pkg::CMD_CLEAR) begin
					state_d = pdw_pkg::ST_CLEAR;
				end else if ((cmd_q == pdw_pkg::CMD_PLOT || cmd_q == pdw_pkg::CMD_READ)
					&& !oob) begin
					state_d = pdw_pkg::ST_READ;
				end else begin
					state_d = pdw_pkg::ST_FINISH;
				end
			end
			pdw_pkg::ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = sweep_q;
				if (sweep_last) begin
					state_d = pdw_pkg::ST_FINISH;
				end
			end
			pdw_pkg::ST_READ: begin
				state_d = pdw_pkg::ST_CHECK;
			end
			pdw_pkg::ST_CHECK: begin
				mem_we  = (cmd_q == pdw_pkg::CMD_PLOT) && !reject;
				state_d = pdw_pkg::ST_FINISH;
			end
			pdw_pkg::ST_FINISH: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = pdw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pdw_pkg::ST_IDLE;
			end
		endcase
	end

	// A clear writes maximum depth and the given colour; a plot the shaded one.
	assign mem_color_wr = (state_q == pdw_pkg::ST_CLEAR) ? color_q : shaded;
	assign mem_depth_wr = (state_q == pdw_pkg::ST_CLEAR) ? pdw_pkg::DEPTH_MAX : depth_q;

	pdw_ram #(
		.WIDTH(pdw_pkg::COLOR_W),
		.DEPTH(pdw_pkg::STORE_SIZE)
	) u_color_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_color_wr),
		.rdata(mem_color_rd)
	);

	pdw_ram #(
		.WIDTH(pdw_pkg::DEPTH_W),
		.DEPTH(pdw_pkg::STORE_SIZE)
	) u_depth_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_depth_wr),
		.rdata(mem_depth_rd)
	);

	// Control state: configuration, sweep counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= pdw_pkg::DIM_W'(256);
			frame_height_q <= pdw_pkg::DIM_W'(256);
			sweep_q        <= '0;
			m_valid_q      <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == pdw_pkg::REG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data;
			end
			if (cfg_we && cfg_index == pdw_pkg::REG_FRAME_HEIGHT) begin
				frame_height_q <= cfg_data;
			end
			if (state_q == pdw_pkg::ST_CLEAR) begin
				sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q   <= s_tuser;
			x_q     <= s_tdata[11:0];
			y_q     <= s_tdata[23:12];
			depth_q <= s_tdata[47:24];
			nx_q    <= s_tdata[63:48];
			ny_q    <= s_tdata[79:64];
			nz_q    <= s_tdata[95:80];
			color_q <= s_tdata[127:96];
		end
		case (state_q)
			pdw_pkg::ST_CALC: begin
				addr_q <= idx_full[AW-1:0];
				prod_q <= (!dot[pdw_pkg::DOT_W-1] && dot != '0)
					? pdw_pkg::PROD_W'(dot[pdw_pkg::DOT_W-2:0]) * pdw_pkg::INV_SQRT3_Q14
					: '0;
				status_q <= ((cmd_q == pdw_pkg::CMD_PLOT || cmd_q == pdw_pkg::CMD_READ) && oob)
					? pdw_pkg::STATUS_OOB : pdw_pkg::STATUS_OK;
				res_color_q <= '0;
				res_depth_q <= '0;
			end
			pdw_pkg::ST_READ: begin
				factor_q <= pdw_pkg::FACTOR_W'(
					((pdw_pkg::PROD_W + 1)'(prod_q) + pdw_pkg::Q14_HALF) >> 14);
			end
			pdw_pkg::ST_CHECK: begin
				if (cmd_q == pdw_pkg::CMD_READ) begin
					res_color_q <= mem_color_rd;
					res_depth_q <= mem_depth_rd;
				end else if (reject) begin
					status_q <= pdw_pkg::STATUS_REJECT;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_data_q <= {res_depth_q, res_color_q};
			m_user_q <= status_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// A transfer in always starts the address stage next.
	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == pdw_pkg::ST_CALC)
		else $error("accepted item did not enter the address stage");

	// Every clear sweep ends with the counter back at the first entry.
	a_sweep_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pdw_pkg::ST_CLEAR && sweep_last) |=> sweep_q == '0)
		else $error("clear sweep did not wrap its counter");

	// Only an in-bounds plot that passes the depth test writes outside a sweep.
	a_write_guard: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != pdw_pkg::ST_CLEAR)
		|-> (cmd_q == pdw_pkg::CMD_PLOT && status_q == pdw_pkg::STATUS_OK))
		else $error("store written by an item that must not write");

	// A waiting result is never overwritten.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_valid_q || m_tready))
		else $error("result register overwritten before its transfer");

endmodule
